// ----- hdl/kab_pkg.sv -----
// Shared types and constants for the binary-lifting ancestor engine.
// No dependencies; every other file in hdl/ refers to it by scoped names.
`default_nettype none

package kab_pkg;

	localparam int NODES_DEF  = 1024;
	localparam int LEVELS_DEF = 10;
	localparam int FIELD_W    = 10;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// One jump-table entry: a valid flag and the index of the node reached.
	typedef struct packed {
		logic               valid;
		logic [FIELD_W-1:0] idx;
	} entry_t;

	localparam entry_t ENTRY_NONE = '{valid: 1'b0, idx: '0};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_B_RD1,
		ST_B_RD2,
		ST_B_WR,
		ST_Q_STEP,
		ST_Q_WAIT
	} state_t;

endpackage

`default_nettype wire

// ----- hdl/kab_table.sv -----
// Jump-table memory: one write port and one read port with registered read data.
// Depends on kab_pkg for the entry type.
`default_nettype none

module kab_table #(
	parameter int ADDR_W = 14
) (
	input  wire                  clk,
	input  wire                  rd_en,
	input  wire [ADDR_W-1:0]     rd_addr,
	output kab_pkg::entry_t      rd_data,
	input  wire                  wr_en,
	input  wire [ADDR_W-1:0]     wr_addr,
	input  kab_pkg::entry_t      wr_data
);

	kab_pkg::entry_t mem_q [2**ADDR_W];
	kab_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- hdl/kth_ancestor_binary_lifting_top.sv -----
// Top level of the binary-lifting ancestor engine: sequencer, walk datapath, result register.
// Depends on kab_pkg and kab_table.
//
// Usage: after reset the block clears level 0 of its jump table, one node per cycle, and
// holds busy high while it does so. A load beat (mode 0) writes one parent and leaves
// busy low. A load beat with load_last set starts the table build, which visits every
// node of levels 1 to LEVELS-1 with one or two dependent reads through the table's
// single read port, with busy high. A query beat (mode 1) walks up one table read per
// set bit of distance with busy high, and the result beat follows with done high.
// Queries that cannot succeed (table not built, node out of range, distance too large)
// and distance zero answer in the next cycle without busy. The result beat lasts one
// cycle and cannot be held off.
`default_nettype none

module kth_ancestor_binary_lifting_top #(
	parameter int NODES  = kab_pkg::NODES_DEF,
	parameter int LEVELS = kab_pkg::LEVELS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire                          mode,
	input  wire [kab_pkg::FIELD_W-1:0]   node,
	input  wire [kab_pkg::FIELD_W-1:0]   parent_of,
	input  wire [kab_pkg::FIELD_W-1:0]   distance,
	input  wire                          load_last,
	output logic                         done,
	output logic                         found,
	output logic [kab_pkg::FIELD_W-1:0]  ancestor
);

	localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam logic [NW-1:0] NODE_LAST  = NW'(NODES - 1);
	localparam logic [LW-1:0] LEVEL_LAST = LW'(LEVELS - 1);

	kab_pkg::state_t state_q, state_d;

	logic [LW-1:0] lvl_q, lvl_d;
	logic [NW-1:0] n_q, n_d;
	logic [LW-1:0] b_q, b_d;
	logic          ready_q, ready_d;
	logic          done_q, done_d;

	logic [kab_pkg::FIELD_W-1:0] cur_q, cur_d;
	logic [kab_pkg::FIELD_W-1:0] dist_q, dist_d;
	logic                        found_q, found_d;
	logic [kab_pkg::FIELD_W-1:0] ancestor_q, ancestor_d;

	logic            rd_en;
	logic [LW-1:0]   rd_lvl;
	logic [NW-1:0]   rd_node;
	kab_pkg::entry_t rd_data;
	logic            wr_en;
	logic [LW-1:0]   wr_lvl;
	logic [NW-1:0]   wr_node;
	kab_pkg::entry_t wr_data;

	logic node_ok;
	logic parent_ok;
	logic query_ok;
	logic build_step;

	kab_table #(
		.ADDR_W(LW + NW)
	) u_table (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr({rd_lvl, rd_node}),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr({wr_lvl, wr_node}),
		.wr_data(wr_data)
	);

	assign node_ok   = (32'(node) < NODES);
	assign parent_ok = (32'(parent_of) < NODES);
	assign query_ok  = ready_q && node_ok && ((distance >> LEVELS) == '0);

	always_comb begin
		state_d    = state_q;
		lvl_d      = lvl_q;
		n_d        = n_q;
		b_d        = b_q;
		ready_d    = ready_q;
		done_d     = 1'b0;
		cur_d      = cur_q;
		dist_d     = dist_q;
		found_d    = found_q;
		ancestor_d = ancestor_q;
		rd_en      = 1'b0;
		rd_lvl     = b_q;
		rd_node    = NW'(cur_q);
		wr_en      = 1'b0;
		wr_lvl     = '0;
		wr_node    = n_q;
		wr_data    = kab_pkg::ENTRY_NONE;
		build_step = 1'b0;

		unique case (state_q)
			kab_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
				if (n_q == NODE_LAST) begin
					n_d     = '0;
					state_d = kab_pkg::ST_IDLE;
				end else begin
					n_d = n_q + 1'b1;
				end
			end
			kab_pkg::ST_IDLE: begin
				if (start) begin
					if (mode == kab_pkg::MODE_LOAD) begin
						ready_d = 1'b0;
						if (node_ok) begin
							wr_en   = 1'b1;
							wr_node = NW'(node);
							if (node != '0 && parent_ok) begin
								wr_data = '{valid: 1'b1, idx: parent_of};
							end
						end
						if (load_last) begin
							if (LEVELS == 1) begin
								ready_d = 1'b1;
							end else begin
								lvl_d   = LW'(1);
								n_d     = '0;
								state_d = kab_pkg::ST_B_RD1;
							end
						end
					end else begin
						if (!query_ok) begin
							done_d     = 1'b1;
							found_d    = 1'b0;
							ancestor_d = '0;
						end else if (distance == '0) begin
							done_d     = 1'b1;
							found_d    = 1'b1;
							ancestor_d = node;
						end else begin
							cur_d   = node;
							dist_d  = distance;
							b_d     = '0;
							state_d = kab_pkg::ST_Q_STEP;
						end
					end
				end
			end
			kab_pkg::ST_B_RD1: begin
				rd_en   = 1'b1;
				rd_lvl  = lvl_q - LW'(1);
				rd_node = n_q;
				state_d = kab_pkg::ST_B_RD2;
			end
			kab_pkg::ST_B_RD2: begin
				// First hop known; a valid hop needs a second read from the same level.
				if (rd_data.valid) begin
					rd_en   = 1'b1;
					rd_lvl  = lvl_q - LW'(1);
					rd_node = NW'(rd_data.idx);
					state_d = kab_pkg::ST_B_WR;
				end else begin
					wr_en      = 1'b1;
					wr_lvl     = lvl_q;
					build_step = 1'b1;
				end
			end
			kab_pkg::ST_B_WR: begin
				wr_en      = 1'b1;
				wr_lvl     = lvl_q;
				wr_data    = rd_data;
				build_step = 1'b1;
			end
			kab_pkg::ST_Q_STEP: begin
				if (dist_q == '0) begin
					done_d     = 1'b1;
					found_d    = 1'b1;
					ancestor_d = cur_q;
					state_d    = kab_pkg::ST_IDLE;
				end else if (dist_q[0]) begin
					rd_en   = 1'b1;
					state_d = kab_pkg::ST_Q_WAIT;
				end else begin
					dist_d = dist_q >> 1;
					b_d    = b_q + LW'(1);
				end
			end
			kab_pkg::ST_Q_WAIT: begin
				if (!rd_data.valid) begin
					done_d     = 1'b1;
					found_d    = 1'b0;
					ancestor_d = '0;
					state_d    = kab_pkg::ST_IDLE;
				end else begin
					cur_d   = rd_data.idx;
					dist_d  = dist_q >> 1;
					b_d     = b_q + LW'(1);
					state_d = kab_pkg::ST_Q_STEP;
				end
			end
			default: begin
				state_d = kab_pkg::ST_IDLE;
			end
		endcase

		if (build_step) begin
			if (n_q == NODE_LAST) begin
				n_d = '0;
				if (lvl_q == LEVEL_LAST) begin
					lvl_d   = '0;
					ready_d = 1'b1;
					state_d = kab_pkg::ST_IDLE;
				end else begin
					lvl_d   = lvl_q + LW'(1);
					state_d = kab_pkg::ST_B_RD1;
				end
			end else begin
				n_d     = n_q + 1'b1;
				state_d = kab_pkg::ST_B_RD1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kab_pkg::ST_CLEAR;
			lvl_q   <= '0;
			n_q     <= '0;
			b_q     <= '0;
			ready_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
			n_q     <= n_d;
			b_q     <= b_d;
			ready_q <= ready_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q      <= cur_d;
		dist_q     <= dist_d;
		found_q    <= found_d;
		ancestor_q <= ancestor_d;
	end

	assign busy     = (state_q != kab_pkg::ST_IDLE);
	assign done     = done_q;
	assign found    = found_q;
	assign ancestor = ancestor_q;

	// A result beat only ever follows the idle state or a step of the walk.
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == kab_pkg::ST_IDLE ||
			$past(state_q) == kab_pkg::ST_Q_STEP || $past(state_q) == kab_pkg::ST_Q_WAIT))
		else $error("result beat outside idle or walk");

	// A miss always reports ancestor zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !found_q) |-> (ancestor_q == '0))
		else $error("not-found result with nonzero ancestor");

	// The walk only runs over a finished table.
	a_walk_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kab_pkg::ST_Q_STEP || state_q == kab_pkg::ST_Q_WAIT) |-> ready_q)
		else $error("walk on an unbuilt table");

	// The table becomes ready only at the end of a build or on a one-level load.
	a_ready_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready_q) |-> ($past(state_q) == kab_pkg::ST_B_RD2 ||
			$past(state_q) == kab_pkg::ST_B_WR || $past(state_q) == kab_pkg::ST_IDLE))
		else $error("table ready raised outside a build");

	// No result beat while the table is being cleared or built.
	a_quiet_build: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kab_pkg::ST_CLEAR || state_q == kab_pkg::ST_B_RD1 ||
			state_q == kab_pkg::ST_B_RD2 || state_q == kab_pkg::ST_B_WR) |=> !done_q)
		else $error("result beat during clear or build");

endmodule

`default_nettype wire
